[rtl/core/infix_expression_evaluator_core_assert.svh]
// Assertion macros used by the checker file
`ifndef INFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define IEE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define IEE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/iee_pkg.sv]
// Shared types, codes and helpers of the infix expression evaluator
package iee_pkg;

  localparam int unsigned ValueDepthDefault = 64;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBadChar  = 2'd1;
  localparam logic [1:0] StDivZero  = 2'd2;
  localparam logic [1:0] StOverflow = 2'd3;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpSub = 2'd1;
  localparam logic [1:0] OpMul = 2'd2;
  localparam logic [1:0] OpDiv = 2'd3;

  // Token classes handed from front to back
  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_SPACE,
    TK_OPER,
    TK_BAD
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] digit;
    logic [1:0] op;
    logic       last;
  } tok_t;

endpackage

[rtl/core/infix_expression_evaluator_core.sv]
// Top level of the infix expression evaluator
// Usage:
//   Input channel: one ASCII character per transfer on ch_i, with last_i set
//   on the final character of an expression. Digits build unsigned numbers,
//   spaces separate tokens, + - * / apply with precedence, left to right.
//   Output channel: one transfer per expression, after its last character,
//   carrying value_o (32-bit signed, wrapping) and status_o (0 ok, 1 invalid
//   character, 2 divide by zero, 3 value stack overflow; value is 0 on error).
//   Token flow: a two-entry token queue sits between the decoder and the
//   evaluator, which takes a token only while idle. A digit is folded into
//   the number; a space or operator pushes it, and an operator then runs up
//   to two reductions (pop, pop, execute, push), a division waiting on the
//   one-bit-per-cycle divider. The result is then read back and registered.
//   Reset clears all control state; the value stack memory is not cleared.
//   A stalled result holds its register; once the queue fills, stall_o rises.
module infix_expression_evaluator_core #(
  parameter int unsigned ValueDepth = iee_pkg::ValueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic signed [31:0] value_o,
  output logic [1:0]  status_o
);
  import iee_pkg::*;

  tok_t tok;
  logic tok_valid, tok_take;
  logic [31:0] value;

  iee_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .ch_i, .last_i,
    .tok_valid_o(tok_valid), .tok_take_i(tok_take), .tok_o(tok)
  );

  iee_back #(.ValueDepth(ValueDepth)) u_back (
    .clk_i, .rst_ni, .tok_valid_i(tok_valid), .tok_take_o(tok_take), .tok_i(tok),
    .valid_o, .stall_i, .value_o(value), .status_o
  );

  assign value_o = value;
endmodule

[rtl/core/iee_front.sv]
// Front end: classify characters and queue tokens
module iee_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  logic [7:0]    ch_i,
  input  logic          last_i,
  output logic          tok_valid_o,
  input  logic          tok_take_i,
  output iee_pkg::tok_t tok_o
);
  import iee_pkg::*;

  tok_t       fifo_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  tok_t       tok_in;
  logic       push, pop;

  // Decode one character
  always_comb begin
    tok_in.digit = ch_i[3:0];
    tok_in.last  = last_i;
    tok_in.op    = OpAdd;
    tok_in.kind  = TK_BAD;
    if (ch_i >= 8'h30 && ch_i <= 8'h39) tok_in.kind = TK_DIGIT;
    else if (ch_i == 8'h20) tok_in.kind = TK_SPACE;
    else if (ch_i == 8'h2b) begin tok_in.kind = TK_OPER; tok_in.op = OpAdd; end
    else if (ch_i == 8'h2d) begin tok_in.kind = TK_OPER; tok_in.op = OpSub; end
    else if (ch_i == 8'h2a) begin tok_in.kind = TK_OPER; tok_in.op = OpMul; end
    else if (ch_i == 8'h2f) begin tok_in.kind = TK_OPER; tok_in.op = OpDiv; end
  end

  assign stall_o     = (cnt_q == 2'd2);
  assign push        = valid_i && !stall_o;
  assign tok_valid_o = (cnt_q != 2'd0);
  assign pop         = tok_valid_o && tok_take_i;
  assign tok_o       = fifo_q[rd_q];

  // Hold queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Store queue payload
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= tok_in;
  end
endmodule

[rtl/core/iee_divider.sv]
// Iterative 32-bit signed divider, truncating toward zero
module iee_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] q_o
);
  logic [31:0] rem_q, quo_q, den_q;
  logic [5:0]  cnt_q;
  logic        busy_q, neg_q, done_q;
  logic [32:0] trial;
  logic [31:0] shifted;

  assign shifted = {rem_q[30:0], quo_q[31]};
  assign trial   = {1'b0, shifted} - {1'b0, den_q};
  assign done_o  = done_q;
  assign q_o     = neg_q ? (32'd0 - quo_q) : quo_q;

  // Advance one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Hold operand and partial result
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 32'd0;
      quo_q <= a_i[31] ? (32'd0 - a_i) : a_i;
      den_q <= b_i[31] ? (32'd0 - b_i) : b_i;
      neg_q <= a_i[31] ^ b_i[31];
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end
endmodule

[rtl/core/iee_back.sv]
// Back end: value stack, operator stack and reduction sequencer
module iee_back #(
  parameter int unsigned ValueDepth = iee_pkg::ValueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tok_valid_i,
  output logic          tok_take_o,
  input  iee_pkg::tok_t tok_i,
  output logic          valid_o,
  input  logic          stall_i,
  output logic [31:0]   value_o,
  output logic [1:0]    status_o
);
  import iee_pkg::*;

  localparam int unsigned TopW = $clog2(ValueDepth + 1);
  localparam int unsigned IdxW = (ValueDepth > 1) ? $clog2(ValueDepth) : 1;
  localparam logic [TopW-1:0] Full = TopW'(ValueDepth);

  typedef enum logic [3:0] {
    S_IDLE, S_NUMPUSH, S_CHECK, S_POPB, S_POPA, S_WAITA, S_EXEC, S_MUL,
    S_DIVWAIT, S_PUSH, S_DONE_OP, S_FINAL_RD, S_FINAL_WAIT, S_OUT
  } state_e;

  state_e          state_q;
  logic [31:0]     mem [ValueDepth];
  logic [31:0]     rd_q;
  logic [TopW-1:0] top_q;
  logic [1:0]      ops_q [2];
  logic [1:0]      opc_q;
  logic [31:0]     acc_q, a_q, b_q, r_q;
  logic            innum_q, last_q, oper_q;
  logic [1:0]      code_q, err_q, rop_q;
  logic            hasb_q, hasa_q;
  logic            valid_q;
  logic [31:0]     val_q;
  logic [1:0]      stat_q;
  logic            div_start, div_done;
  logic [31:0]     div_q;
  logic            mem_we, mem_re;
  logic [IdxW-1:0] wa, ra;
  logic [31:0]     wd;
  logic [1:0]      topop;
  logic            need_red;

  iee_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .a_i(a_q), .b_i(b_q),
    .done_o(div_done), .q_o(div_q)
  );

  assign topop     = ops_q[opc_q[0] ? 1'b0 : 1'b1];
  // For a new operator, reduce while the pending top binds at least as tight,
  // or the stack is full; at the end of an expression, reduce everything
  assign need_red  = (opc_q != 2'd0) &&
                     (oper_q ? (topop[1] >= code_q[1] || opc_q == 2'd2) : last_q);
  assign tok_take_o = (state_q == S_IDLE) && tok_valid_i;
  assign valid_o   = valid_q;
  assign value_o   = val_q;
  assign status_o  = stat_q;
  assign div_start = (state_q == S_EXEC) && (rop_q == OpDiv) && (b_q != 32'd0);

  // Memory port control
  always_comb begin
    mem_we = 1'b0;
    wd     = acc_q;
    mem_re = 1'b0;
    ra     = IdxW'(top_q - TopW'(1));
    wa     = IdxW'(top_q);
    if (state_q == S_NUMPUSH && innum_q && err_q == StOk && top_q < Full) mem_we = 1'b1;
    if (state_q == S_PUSH && err_q == StOk && top_q < Full) begin
      mem_we = 1'b1;
      wd     = r_q;
    end
    if ((state_q == S_POPB || state_q == S_POPA || state_q == S_FINAL_RD) &&
        top_q != '0) mem_re = 1'b1;
  end

  // Hold the value stack
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wa] <= wd;
    if (mem_re) rd_q <= mem[ra];
  end

  // Sequence tokens and reductions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      top_q   <= '0;
      opc_q   <= 2'd0;
      acc_q   <= 32'd0;
      innum_q <= 1'b0;
      err_q   <= StOk;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      oper_q  <= 1'b0;
      code_q  <= OpAdd;
      hasa_q  <= 1'b0;
      hasb_q  <= 1'b0;
    end else begin
      if (valid_q && !stall_i && state_q != S_OUT) valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (tok_valid_i) begin
          last_q <= tok_i.last;
          oper_q <= (tok_i.kind == TK_OPER);
          code_q <= tok_i.op;
          if (err_q != StOk) state_q <= tok_i.last ? S_FINAL_RD : S_IDLE;
          else if (tok_i.kind == TK_DIGIT) begin
            acc_q   <= (acc_q << 3) + (acc_q << 1) + {28'd0, tok_i.digit};
            innum_q <= 1'b1;
            state_q <= tok_i.last ? S_NUMPUSH : S_IDLE;
          end else if (tok_i.kind == TK_BAD) begin
            err_q   <= StBadChar;
            state_q <= tok_i.last ? S_FINAL_RD : S_IDLE;
          end else state_q <= S_NUMPUSH;
        end
        S_NUMPUSH: begin
          if (innum_q) begin
            if (top_q < Full) top_q <= top_q + TopW'(1);
            else err_q <= StOverflow;
          end
          innum_q <= 1'b0;
          acc_q   <= 32'd0;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (err_q != StOk) state_q <= last_q ? S_FINAL_RD : S_IDLE;
          else if (need_red) begin
            rop_q   <= topop;
            opc_q   <= opc_q - 2'd1;
            state_q <= S_POPB;
          end else begin
            if (oper_q) begin
              ops_q[opc_q[0]] <= code_q;
              opc_q <= opc_q + 2'd1;
              oper_q <= 1'b0;
              state_q <= S_CHECK;
            end else state_q <= last_q ? S_FINAL_RD : S_IDLE;
          end
        end
        S_POPB: begin
          hasb_q <= (top_q != '0);
          if (top_q != '0) top_q <= top_q - TopW'(1);
          state_q <= S_POPA;
        end
        S_POPA: begin
          b_q    <= hasb_q ? rd_q : 32'd0;
          hasa_q <= (top_q != '0);
          if (top_q != '0) top_q <= top_q - TopW'(1);
          state_q <= S_WAITA;
        end
        S_WAITA: begin
          a_q     <= hasa_q ? rd_q : 32'd0;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          case (rop_q)
            OpAdd: begin r_q <= a_q + b_q; state_q <= S_PUSH; end
            OpSub: begin r_q <= a_q - b_q; state_q <= S_PUSH; end
            OpMul: state_q <= S_MUL;
            default: begin
              if (b_q == 32'd0) begin
                err_q   <= StDivZero;
                state_q <= S_CHECK;
              end else state_q <= S_DIVWAIT;
            end
          endcase
        end
        S_MUL: begin
          r_q     <= a_q * b_q;
          state_q <= S_PUSH;
        end
        S_DIVWAIT: if (div_done) begin
          r_q     <= div_q;
          state_q <= S_PUSH;
        end
        S_PUSH: begin
          if (top_q < Full) top_q <= top_q + TopW'(1);
          else err_q <= StOverflow;
          state_q <= S_CHECK;
        end
        S_DONE_OP: state_q <= S_CHECK;
        S_FINAL_RD: state_q <= S_FINAL_WAIT;
        S_FINAL_WAIT: state_q <= S_OUT;
        S_OUT: if (!valid_q || !stall_i) begin
          valid_q <= 1'b1;
          stat_q  <= err_q;
          val_q   <= (err_q == StOk && top_q != '0) ? rd_q : 32'd0;
          top_q   <= '0;
          opc_q   <= 2'd0;
          acc_q   <= 32'd0;
          innum_q <= 1'b0;
          err_q   <= StOk;
          oper_q  <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/iee_checker.sv]
// Port checker for the infix expression evaluator, bound to the top level
`include "infix_expression_evaluator_core_assert.svh"
module iee_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] value_o,
  input logic [1:0]  status_o
);
  import iee_pkg::*;

  `IEE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(value_o) && $stable(status_o), "stalled result changed")
  `IEE_ASSERT_IMP(a_err_zero, clk_i, rst_ni, valid_o && status_o != StOk, value_o == 32'd0, "error result has nonzero value")
  `IEE_ASSERT_NXT(a_in_hold, clk_i, rst_ni, valid_i && stall_o, valid_i, "stalled input dropped")
endmodule

bind infix_expression_evaluator_core iee_checker u_iee_checker (
  .clk_i, .rst_ni, .valid_i, .stall_o, .valid_o, .stall_i,
  .value_o, .status_o
);
